[src/palette_indexer_rgb555_top_defines.svh]
// Assertion helpers used by the top-level RTL.
`ifndef PALETTE_INDEXER_RGB555_TOP_DEFINES_SVH
`define PALETTE_INDEXER_RGB555_TOP_DEFINES_SVH

// Same-cycle implication, checked out of reset.
`define PALIDX_ASSERT_NOW(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) else $error(msg);

// Next-cycle implication, checked out of reset.
`define PALIDX_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) else $error(msg);

`endif

[src/palidx_pkg.sv]
package palidx_pkg;

	// Default palette depth and the 4bpp colour limit
	localparam int PALETTE_DEPTH_DEF = 256;
	localparam int NIBBLE_CAP        = 16;

	// Mode register reset: 8bpp
	localparam logic BPP_MODE_RESET = 1'b1;
	localparam logic BPP_MODE_4     = 1'b0;

	// Input pixel request
	typedef struct packed {
		logic       start_image;
		logic [7:0] red;
		logic [7:0] green;
		logic [7:0] blue;
		logic [7:0] alpha;
	} palidx_in_t;

	// Result request
	typedef struct packed {
		logic [14:0] colour_word;
		logic [7:0]  palette_index;
		logic        new_entry;
		logic        byte_valid;
		logic [7:0]  packed_byte;
		logic        overflow;
	} palidx_out_t;

	// Status from the search unit back to the sequencer
	typedef struct packed {
		logic       done;
		logic       hit;
		logic [7:0] idx;
	} palidx_srch_t;

endpackage

[src/palidx_search.sv]
module palidx_search
	import palidx_pkg::*;
#(
	parameter int PALETTE_DEPTH = PALETTE_DEPTH_DEF,
	localparam int IDX_W = $clog2(PALETTE_DEPTH),
	localparam int CNT_W = $clog2(PALETTE_DEPTH + 1)
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               go,
	input  logic [14:0]        colour,
	input  logic [CNT_W-1:0]   limit,
	input  logic               wr_en,
	input  logic [IDX_W-1:0]   wr_addr,
	input  logic [14:0]        wr_data,
	output palidx_srch_t       status
);

	logic [14:0]      mem [PALETTE_DEPTH];
	logic             active_q;
	logic [CNT_W-1:0] addr_q;
	logic             rd_vld_s1;
	logic [IDX_W-1:0] rd_idx_s1;
	logic [14:0]      rd_data_s1;
	logic             hit;
	logic             more;
	logic             issue;
	logic             miss_end;

	// One entry read per cycle, compared the cycle after
	assign hit      = rd_vld_s1 && (rd_data_s1 == colour);
	assign more     = addr_q < limit;
	assign issue    = active_q && !hit && more;
	assign miss_end = active_q && !hit && !more && !rd_vld_s1;

	assign status.done = active_q && (hit || miss_end);
	assign status.hit  = hit;
	assign status.idx  = 8'(rd_idx_s1);

	// Palette storage: one write port, one registered read port
	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
		if (issue) begin
			rd_data_s1 <= mem[addr_q[IDX_W-1:0]];
			rd_idx_s1  <= addr_q[IDX_W-1:0];
		end
	end

	// Scan sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			active_q  <= 1'b0;
			addr_q    <= '0;
			rd_vld_s1 <= 1'b0;
		end else begin
			rd_vld_s1 <= issue;
			if (go) begin
				active_q <= 1'b1;
				addr_q   <= '0;
			end else if (status.done) begin
				active_q <= 1'b0;
			end else if (issue) begin
				addr_q <= addr_q + 1'b1;
			end
		end
	end

endmodule

[src/palette_indexer_rgb555_top.sv]
// Flow: an accepted pixel starts the search unit, which scans palette entries until a
// hit or until limit entries are compared; limit is the number of palette entries searched
// (palette fill, capped at 16 in 4bpp mode). The read port scans one entry per cycle.
// One pixel is taken at a time: pixel_stall holds until its result is written, and
// result_stall holds it longer. A finished result waits in its register.
// Reset (arst_n, asynchronous): empty palette, no half byte, overflow clear, 8bpp mode.
module palette_indexer_rgb555_top
	import palidx_pkg::*;
#(
	parameter int PALETTE_DEPTH = PALETTE_DEPTH_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        pixel_valid,
	output logic        pixel_stall,
	input  palidx_in_t  pixel,
	output logic        result_valid,
	input  logic        result_stall,
	output palidx_out_t result,
	input  logic        bpp_we,
	input  logic        bpp_wdata
);

`include "palette_indexer_rgb555_top_defines.svh"

	localparam int IDX_W = $clog2(PALETTE_DEPTH);
	localparam int CNT_W = $clog2(PALETTE_DEPTH + 1);

	typedef enum logic [2:0] {
		ST_IDLE   = 3'b001,
		ST_SEARCH = 3'b010,
		ST_WRAP   = 3'b100
	} state_t;

	state_t           state_q;
	logic             bpp_q;
	logic [CNT_W-1:0] count_q;
	logic [3:0]       held_q;
	logic             half_q;
	logic             ovf_q;
	logic             go_q;
	logic             result_valid_q;
	logic [14:0]      colour_q;
	logic             hit_q;
	logic [7:0]       hit_idx_q;
	palidx_out_t      result_q;

	palidx_srch_t     srch;
	logic             accept;
	logic             fire;
	logic [CNT_W-1:0] cap;
	logic [CNT_W-1:0] limit;
	logic             full;
	logic             wr_en;
	logic [7:0]       idx;
	logic             fresh;
	logic             ovf_d;
	logic             bvalid;
	logic [7:0]       pbyte;
	logic             half_d;
	logic [3:0]       held_d;

	// RGBA8888 to BGR555 (blue high); transparent pixels map to zero, opaque never do
	function automatic logic [14:0] make_colour(input palidx_in_t p);
		logic [4:0] bc;
		bc = p.blue[7:3];
		if (bc == 5'd0) begin
			bc = 5'd1;
		end
		if (!p.alpha[7]) begin
			return 15'd0;
		end
		return {bc, p.green[7:3], p.red[7:3]};
	endfunction

	assign accept       = (state_q == ST_IDLE) && pixel_valid;
	assign pixel_stall  = (state_q != ST_IDLE);
	assign fire         = (state_q == ST_WRAP) && (!result_valid_q || !result_stall);
	assign result_valid = result_valid_q;
	assign result       = result_q;

	// Palette limit for the current mode
	assign cap   = bpp_q ? CNT_W'(PALETTE_DEPTH) : CNT_W'(NIBBLE_CAP);
	assign limit = (count_q < cap) ? count_q : cap;
	assign full  = count_q >= cap;
	assign wr_en = fire && !hit_q && !full;

	// Index choice and nibble packing
	always_comb begin
		idx    = 8'd0;
		fresh  = 1'b0;
		ovf_d  = ovf_q;
		bvalid = 1'b0;
		pbyte  = 8'd0;
		half_d = 1'b0;
		held_d = 4'd0;
		if (hit_q) begin
			idx = hit_idx_q;
		end else if (full) begin
			ovf_d = 1'b1;
		end else begin
			idx   = 8'(count_q);
			fresh = 1'b1;
		end
		if (bpp_q != BPP_MODE_4) begin
			bvalid = 1'b1;
			pbyte  = idx;
		end else if (!half_q) begin
			half_d = 1'b1;
			held_d = idx[3:0];
		end else begin
			bvalid = 1'b1;
			pbyte  = {idx[3:0], held_q};
		end
	end

	palidx_search #(
		.PALETTE_DEPTH(PALETTE_DEPTH)
	) u_search (
		.clk     (clk),
		.arst_n  (arst_n),
		.go      (go_q),
		.colour  (colour_q),
		.limit   (limit),
		.wr_en   (wr_en),
		.wr_addr (count_q[IDX_W-1:0]),
		.wr_data (colour_q),
		.status  (srch)
	);

	// Sequencer and image state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q        <= ST_IDLE;
			bpp_q          <= BPP_MODE_RESET;
			count_q        <= '0;
			held_q         <= 4'd0;
			half_q         <= 1'b0;
			ovf_q          <= 1'b0;
			go_q           <= 1'b0;
			result_valid_q <= 1'b0;
		end else begin
			go_q <= 1'b0;
			if (bpp_we) begin
				bpp_q <= bpp_wdata;
			end
			if (result_valid_q && !result_stall) begin
				result_valid_q <= 1'b0;
			end
			case (state_q)
				ST_IDLE: begin
					if (accept) begin
						if (pixel.start_image) begin
							count_q <= '0;
							held_q  <= 4'd0;
							half_q  <= 1'b0;
							ovf_q   <= 1'b0;
						end
						go_q    <= 1'b1;
						state_q <= ST_SEARCH;
					end
				end
				ST_SEARCH: begin
					if (srch.done) begin
						state_q <= ST_WRAP;
					end
				end
				ST_WRAP: begin
					if (fire) begin
						if (wr_en) begin
							count_q <= count_q + 1'b1;
						end
						ovf_q          <= ovf_d;
						half_q         <= half_d;
						held_q         <= held_d;
						result_valid_q <= 1'b1;
						state_q        <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	// Payload registers
	always_ff @(posedge clk) begin
		if (accept) begin
			colour_q <= make_colour(pixel);
		end
		if ((state_q == ST_SEARCH) && srch.done) begin
			hit_q     <= srch.hit;
			hit_idx_q <= srch.idx;
		end
		if (fire) begin
			result_q.colour_word   <= colour_q;
			result_q.palette_index <= idx;
			result_q.new_entry     <= fresh;
			result_q.byte_valid    <= bvalid;
			result_q.packed_byte   <= pbyte;
			result_q.overflow      <= ovf_d;
		end
	end

	`PALIDX_ASSERT_NEXT(a_accept_starts_search, accept, (state_q == ST_SEARCH) && go_q, "accepted pixel did not start a search")
	`PALIDX_ASSERT_NOW(a_done_in_search, srch.done, state_q == ST_SEARCH, "search finished outside the search state")
	`PALIDX_ASSERT_NOW(a_append_below_cap, wr_en, count_q < cap, "palette append beyond the cap")
	`PALIDX_ASSERT_NOW(a_4bpp_index_range, result_valid_q && (bpp_q == BPP_MODE_4), result_q.palette_index < 8'd16, "4bpp index out of range")

endmodule
